@@ hw/rtl/sorted_min_priority_queue_assert.svh @@
// assertion macros for the sorted minimum priority queue
`ifndef SORTED_MIN_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_MIN_PRIORITY_QUEUE_ASSERT_SVH

// property must hold on every edge outside reset
`define SMPQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent must hold in the cycle after the trigger
`define SMPQ_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/smpq_pkg.sv @@
// shared types and constants for the sorted minimum priority queue
package smpq_pkg;

  localparam int VALUE_W        = 16;
  localparam int COUNT_W        = 5;
  localparam int TOTAL_W        = 20;
  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_VALUE_BITS = 16;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctl_t;

  typedef struct packed {
    logic               ok;
    logic [COUNT_W-1:0] count;
    logic [TOTAL_W-1:0] total;
    logic [VALUE_W-1:0] smallest;
    logic               empty_res;
  } res_t;

endpackage

@@ hw/rtl/sorted_min_priority_queue.sv @@
// sorted minimum priority queue: chain of compare-and-shift cells
//
//   channel | direction | fields
//   req     | in        | operation, value
//   rsp     | out       | ok, count, total, smallest, empty_res
//
// every cell compares against the key and shifts in the same cycle, and the result
// is registered at the accepting edge, in the skid stage instead while rsp is stalled.
// a beat is taken every cycle until the result register and its skid stage are both full.
// rsp_stall holds the result; a second beat lands in the skid stage, then req_stall rises.
// reset clears the entry count, the running sum and both output stages; cell values stay
// undefined and are never read below the count.
`include "sorted_min_priority_queue_assert.svh"

module sorted_min_priority_queue #(
  parameter int CAPACITY   = smpq_pkg::DEF_CAPACITY,
  parameter int VALUE_BITS = smpq_pkg::DEF_VALUE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic                          operation,
  input  logic [smpq_pkg::VALUE_W-1:0]  value,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic                          ok,
  output logic [smpq_pkg::COUNT_W-1:0]  count,
  output logic [smpq_pkg::TOTAL_W-1:0]  total,
  output logic [smpq_pkg::VALUE_W-1:0]  smallest,
  output logic                          empty_res
);
  import smpq_pkg::*;

  localparam int KEY_W = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = KEY_W + CNT_W;

  logic [CNT_W-1:0] cnt, cnt_next;
  logic [SUM_W-1:0] sum, sum_next;
  logic [KEY_W-1:0] key;
  logic             accept, full, empty, ins_ok, rem_ok;
  cell_ctl_t        ctl;
  res_t             res, res_q;

  logic [KEY_W-1:0] cell_val [CAPACITY];
  logic [KEY_W-1:0] cell_nx  [CAPACITY];
  logic             cell_lt  [CAPACITY];

  assign key    = value[KEY_W-1:0];
  assign accept = req_valid && !req_stall;
  assign full   = (cnt == CNT_W'(CAPACITY));
  assign empty  = (cnt == '0);
  assign ins_ok = (op_t'(operation) == OP_INSERT) && !full;
  assign rem_ok = (op_t'(operation) == OP_REMOVE) && !empty;
  assign ctl.ins = accept && ins_ok;
  assign ctl.rem = accept && rem_ok;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_W-1:0] lv, rv;
    logic             llt;
    if (i == 0) begin : g_head
      // head cell takes the key on an insert whenever it does not keep its own value
      assign lv  = key;
      assign llt = 1'b0;
    end else begin : g_mid
      assign lv  = cell_val[i-1];
      assign llt = cell_lt[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign rv = cell_val[i];
    end else begin : g_inner
      assign rv = cell_val[i+1];
    end
    smpq_cell #(.KEY_W(KEY_W)) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .occupied (cnt > CNT_W'(i)),
      .key      (key),
      .left_val (lv),
      .left_lt  (llt),
      .right_val(rv),
      .val      (cell_val[i]),
      .val_next (cell_nx[i]),
      .lt       (cell_lt[i])
    );
  end

  always_comb begin
    cnt_next = cnt;
    sum_next = sum;
    if (ctl.ins) begin
      cnt_next = cnt + 1'b1;
      sum_next = sum + SUM_W'(key);
    end else if (ctl.rem) begin
      cnt_next = cnt - 1'b1;
      sum_next = sum - SUM_W'(cell_val[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      sum <= '0;
    end else begin
      cnt <= cnt_next;
      sum <= sum_next;
    end
  end

  always_comb begin
    res.ok        = (op_t'(operation) == OP_INSERT) ? ins_ok : rem_ok;
    res.count     = COUNT_W'(cnt_next);
    res.total     = TOTAL_W'(sum_next);
    res.smallest  = (cnt_next != '0) ? VALUE_W'(cell_nx[0]) : '0;
    res.empty_res = (cnt_next == '0);
  end

  smpq_obuf u_obuf (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .din      (res),
    .out_stall(rsp_stall),
    .out_valid(rsp_valid),
    .dout     (res_q),
    .full     (req_stall)
  );

  assign ok        = res_q.ok;
  assign count     = res_q.count;
  assign total     = res_q.total;
  assign smallest  = res_q.smallest;
  assign empty_res = res_q.empty_res;

  `SMPQ_ASSERT_ALWAYS(a_cnt_bound, cnt <= CNT_W'(CAPACITY), "entry count above capacity")
  `SMPQ_ASSERT_ALWAYS(a_empty_sum, (cnt != '0) || (sum == '0), "nonzero sum with no entries")
  `SMPQ_ASSERT_NEXT(a_ins_count, ctl.ins, cnt == CNT_W'($past(cnt) + 1'b1), "insert lost count")
  `SMPQ_ASSERT_ALWAYS(a_skid_order, !req_stall || rsp_valid, "skid stage filled ahead of output")

endmodule

@@ hw/rtl/smpq_cell.sv @@
// one storage cell of the sorted chain
module smpq_cell #(
  parameter int KEY_W = smpq_pkg::VALUE_W
) (
  input  logic                 clk,
  input  smpq_pkg::cell_ctl_t  ctl,
  input  logic                 occupied,
  input  logic [KEY_W-1:0]     key,
  input  logic [KEY_W-1:0]     left_val,
  input  logic                 left_lt,
  input  logic [KEY_W-1:0]     right_val,
  output logic [KEY_W-1:0]     val,
  output logic [KEY_W-1:0]     val_next,
  output logic                 lt
);
  import smpq_pkg::*;

  // cell is occupied and its stored value is strictly below the key, so the key lands further right
  assign lt = occupied && (val < key);

  always_comb begin
    val_next = val;
    if (ctl.ins) begin
      if (!lt) begin
        val_next = left_lt ? key : left_val;
      end
    end else if (ctl.rem) begin
      val_next = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

@@ hw/rtl/smpq_obuf.sv @@
// result register with a skid stage
module smpq_obuf (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  smpq_pkg::res_t  din,
  input  logic            out_stall,
  output logic            out_valid,
  output smpq_pkg::res_t  dout,
  output logic            full
);
  import smpq_pkg::*;

  logic skid_valid;
  res_t skid;

  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        dout <= skid;
      end else if (push) begin
        dout <= din;
      end
    end else if (push) begin
      skid <= din;
    end
  end

endmodule
